// ===== sv/z80br_pkg.sv =====
// ----------------------------------------------------------------------------
// z80br_pkg
// Shared types and constants for the Z80 branch resolve pipeline.
// ----------------------------------------------------------------------------
package z80br_pkg;

  // control-flow instruction kinds
  typedef enum logic [3:0] {
    ACT_NOP     = 4'd0,
    ACT_DJNZ    = 4'd1,
    ACT_JR      = 4'd2,
    ACT_JR_CC   = 4'd3,
    ACT_JP      = 4'd4,
    ACT_JP_CC   = 4'd5,
    ACT_JP_HL   = 4'd6,
    ACT_CALL    = 4'd7,
    ACT_CALL_CC = 4'd8,
    ACT_RET     = 4'd9,
    ACT_RET_CC  = 4'd10,
    ACT_RST     = 4'd11
  } action_t;

  // condition codes from opcode bits 5:3
  typedef enum logic [2:0] {
    CC_NZ = 3'd0,
    CC_Z  = 3'd1,
    CC_NC = 3'd2,
    CC_C  = 3'd3,
    CC_PO = 3'd4,
    CC_PE = 3'd5,
    CC_P  = 3'd6,
    CC_M  = 3'd7
  } cond_t;

  localparam logic [7:0]  RST_MASK   = 8'h38;
  localparam logic [15:0] STACK_STEP = 16'd2;

  // one incoming request
  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  opcode;
    logic [15:0] operand;
    logic [15:0] pc;
    logic        flag_s;
    logic        flag_z;
    logic        flag_pv;
    logic        flag_c;
    logic [7:0]  reg_b;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] popped_value;
  } in_item_t;

  // after decode: condition resolved, offset sign-extended
  typedef struct packed {
    logic [3:0]  action;
    logic        cond;
    logic [15:0] offset;
    logic [7:0]  rst_vec;
    logic [15:0] operand;
    logic [15:0] pc;
    logic [7:0]  reg_b;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] popped_value;
  } dec_t;

  // after execute: all candidate values computed
  typedef struct packed {
    logic [3:0]  action;
    logic        cond;
    logic [7:0]  rst_vec;
    logic [15:0] operand;
    logic [15:0] pc;
    logic [15:0] rel_pc;
    logic [15:0] pc_inc;
    logic [7:0]  b_dec;
    logic        b_dec_zero;
    logic [7:0]  reg_b;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] sp_dec;
    logic [15:0] sp_inc;
    logic [15:0] popped_value;
  } ex_t;

  // one result
  typedef struct packed {
    logic [15:0] next_pc;
    logic [7:0]  next_b;
    logic [15:0] next_sp;
    logic        push_valid;
    logic [15:0] push_value;
    logic        pop_used;
    logic        memptr_write;
    logic [15:0] memptr_value;
    logic        taken;
  } out_item_t;

endpackage

// ===== sv/z80br_in_if.sv =====
// ----------------------------------------------------------------------------
// z80br_in_if
// Instruction request channel: valid/ready handshake with payload fields.
// ----------------------------------------------------------------------------
interface z80br_in_if;

  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [7:0]  opcode;
  logic [15:0] operand;
  logic [15:0] pc;
  logic        flag_s;
  logic        flag_z;
  logic        flag_pv;
  logic        flag_c;
  logic [7:0]  reg_b;
  logic [15:0] hl;
  logic [15:0] sp;
  logic [15:0] popped_value;

  modport source (
    output valid, action, opcode, operand, pc, flag_s, flag_z, flag_pv, flag_c,
           reg_b, hl, sp, popped_value,
    input  ready
  );

  modport sink (
    input  valid, action, opcode, operand, pc, flag_s, flag_z, flag_pv, flag_c,
           reg_b, hl, sp, popped_value,
    output ready
  );

endinterface

// ===== sv/z80br_out_if.sv =====
// ----------------------------------------------------------------------------
// z80br_out_if
// Result channel: valid/ready handshake with the resolved branch fields.
// ----------------------------------------------------------------------------
interface z80br_out_if;

  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [7:0]  next_b;
  logic [15:0] next_sp;
  logic        push_valid;
  logic [15:0] push_value;
  logic        pop_used;
  logic        memptr_write;
  logic [15:0] memptr_value;
  logic        taken;

  modport source (
    output valid, next_pc, next_b, next_sp, push_valid, push_value, pop_used,
           memptr_write, memptr_value, taken,
    input  ready
  );

  modport sink (
    input  valid, next_pc, next_b, next_sp, push_valid, push_value, pop_used,
           memptr_write, memptr_value, taken,
    output ready
  );

endinterface

// ===== sv/z80br_decode.sv =====
// ----------------------------------------------------------------------------
// z80br_decode
// Stage 1: condition evaluation, offset sign extension, restart vector.
// ----------------------------------------------------------------------------
module z80br_decode import z80br_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     valid_in,
  input  in_item_t item,
  output logic     valid,
  output dec_t     dec
);

  logic cond8;
  logic cond4;
  dec_t dec_next;

  // full eight-way condition from opcode bits 5:3
  always_comb begin
    case (cond_t'(item.opcode[5:3]))
      CC_NZ:   cond8 = !item.flag_z;
      CC_Z:    cond8 = item.flag_z;
      CC_NC:   cond8 = !item.flag_c;
      CC_C:    cond8 = item.flag_c;
      CC_PO:   cond8 = !item.flag_pv;
      CC_PE:   cond8 = item.flag_pv;
      CC_P:    cond8 = !item.flag_s;
      CC_M:    cond8 = item.flag_s;
      default: cond8 = 1'b0;
    endcase
  end

  // jr cc tests only nz/z/nc/c from bits 4:3
  always_comb begin
    case (cond_t'({1'b0, item.opcode[4:3]}))
      CC_NZ:   cond4 = !item.flag_z;
      CC_Z:    cond4 = item.flag_z;
      CC_NC:   cond4 = !item.flag_c;
      default: cond4 = item.flag_c;
    endcase
  end

  // pack the decoded request
  always_comb begin
    dec_next.action       = item.action;
    dec_next.cond         = (item.action == ACT_JR_CC) ? cond4 : cond8;
    dec_next.offset       = {{8{item.operand[7]}}, item.operand[7:0]};
    dec_next.rst_vec      = item.opcode & RST_MASK;
    dec_next.operand      = item.operand;
    dec_next.pc           = item.pc;
    dec_next.reg_b        = item.reg_b;
    dec_next.hl           = item.hl;
    dec_next.sp           = item.sp;
    dec_next.popped_value = item.popped_value;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      dec <= dec_next;
    end
  end

endmodule

// ===== sv/z80br_exec.sv =====
// ----------------------------------------------------------------------------
// z80br_exec
// Stage 2: address and counter arithmetic, all wrapping.
// ----------------------------------------------------------------------------
module z80br_exec import z80br_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic valid_in,
  input  dec_t dec,
  output logic valid,
  output ex_t  ex
);

  ex_t ex_next;

  // candidate targets and updated registers
  always_comb begin
    ex_next.action       = dec.action;
    ex_next.cond         = dec.cond;
    ex_next.rst_vec      = dec.rst_vec;
    ex_next.operand      = dec.operand;
    ex_next.pc           = dec.pc;
    ex_next.rel_pc       = dec.pc + dec.offset;
    ex_next.pc_inc       = dec.pc + 16'd1;
    ex_next.b_dec        = dec.reg_b - 8'd1;
    ex_next.b_dec_zero   = (dec.reg_b == 8'd1);
    ex_next.reg_b        = dec.reg_b;
    ex_next.hl           = dec.hl;
    ex_next.sp           = dec.sp;
    ex_next.sp_dec       = dec.sp - STACK_STEP;
    ex_next.sp_inc       = dec.sp + STACK_STEP;
    ex_next.popped_value = dec.popped_value;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      ex <= ex_next;
    end
  end

endmodule

// ===== sv/z80br_select.sv =====
// ----------------------------------------------------------------------------
// z80br_select
// Stage 3: picks outputs per instruction kind into the result register.
// ----------------------------------------------------------------------------
module z80br_select import z80br_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      valid_in,
  input  ex_t       ex,
  output logic      valid,
  output out_item_t res
);

  out_item_t res_next;

  // per-kind result selection
  always_comb begin
    res_next.next_pc      = ex.pc;
    res_next.next_b       = ex.reg_b;
    res_next.next_sp      = ex.sp;
    res_next.push_valid   = 1'b0;
    res_next.push_value   = 16'd0;
    res_next.pop_used     = 1'b0;
    res_next.memptr_write = 1'b0;
    res_next.memptr_value = 16'd0;
    res_next.taken        = 1'b0;
    case (ex.action)
      ACT_DJNZ: begin
        res_next.next_b = ex.b_dec;
        if (!ex.b_dec_zero) begin
          res_next.next_pc = ex.rel_pc;
          res_next.taken   = 1'b1;
        end
      end
      ACT_JR: begin
        res_next.next_pc      = ex.rel_pc;
        res_next.taken        = 1'b1;
        res_next.memptr_write = 1'b1;
        res_next.memptr_value = ex.rel_pc;
      end
      ACT_JR_CC: begin
        if (ex.cond) begin
          res_next.next_pc = ex.rel_pc;
          res_next.taken   = 1'b1;
        end
      end
      ACT_JP: begin
        res_next.next_pc      = ex.operand;
        res_next.taken        = 1'b1;
        res_next.memptr_write = 1'b1;
        res_next.memptr_value = ex.operand;
      end
      ACT_JP_CC: begin
        res_next.memptr_write = 1'b1;
        res_next.memptr_value = ex.operand;
        if (ex.cond) begin
          res_next.next_pc = ex.operand;
          res_next.taken   = 1'b1;
        end
      end
      ACT_JP_HL: begin
        res_next.next_pc = ex.hl;
        res_next.taken   = 1'b1;
      end
      ACT_CALL, ACT_CALL_CC: begin
        res_next.memptr_write = 1'b1;
        res_next.memptr_value = ex.operand;
        if (ex.action == ACT_CALL || ex.cond) begin
          res_next.next_sp    = ex.sp_dec;
          res_next.push_valid = 1'b1;
          res_next.push_value = ex.pc;
          res_next.next_pc    = ex.operand;
          res_next.taken      = 1'b1;
        end
      end
      ACT_RET: begin
        res_next.next_pc      = ex.popped_value;
        res_next.next_sp      = ex.sp_inc;
        res_next.pop_used     = 1'b1;
        res_next.taken        = 1'b1;
        res_next.memptr_write = 1'b1;
        res_next.memptr_value = ex.popped_value;
      end
      ACT_RET_CC: begin
        if (ex.cond) begin
          res_next.next_pc  = ex.popped_value;
          res_next.next_sp  = ex.sp_inc;
          res_next.pop_used = 1'b1;
          res_next.taken    = 1'b1;
        end
      end
      ACT_RST: begin
        res_next.next_sp      = ex.sp_dec;
        res_next.push_valid   = 1'b1;
        res_next.push_value   = ex.pc_inc;
        res_next.next_pc      = {8'd0, ex.rst_vec};
        res_next.taken        = 1'b1;
        res_next.memptr_write = 1'b1;
        res_next.memptr_value = {8'd0, ex.rst_vec};
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// ===== sv/z80_branch_resolve_core.sv =====
// An accepted request passes through the decode, arithmetic and select registers to the output.
// Throughput: one request per cycle; the three stage registers (decode,
// arithmetic, select) advance together whenever the output is empty or taken.
// Reset: synchronous active-high rst clears all stage valid bits; the
// pipeline then holds no requests and ready is high.
// ----------------------------------------------------------------------------
// z80_branch_resolve_core
// Resolves Z80 control-flow instructions through a three-stage pipeline.
// ----------------------------------------------------------------------------
module z80_branch_resolve_core import z80br_pkg::*; (
  input logic       clk,
  input logic       rst,
  z80br_in_if.sink  instr,
  z80br_out_if.source result
);

  logic      advance;
  in_item_t  item;
  logic      dec_valid;
  dec_t      dec;
  logic      ex_valid;
  ex_t       ex;
  logic      res_valid;
  out_item_t res;

  // whole pipe moves when the output slot is free or being drained
  assign advance     = !res_valid || result.ready;
  assign instr.ready = advance;

  // gather the request payload
  always_comb begin
    item.action       = instr.action;
    item.opcode       = instr.opcode;
    item.operand      = instr.operand;
    item.pc           = instr.pc;
    item.flag_s       = instr.flag_s;
    item.flag_z       = instr.flag_z;
    item.flag_pv      = instr.flag_pv;
    item.flag_c       = instr.flag_c;
    item.reg_b        = instr.reg_b;
    item.hl           = instr.hl;
    item.sp           = instr.sp;
    item.popped_value = instr.popped_value;
  end

  z80br_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .valid_in (instr.valid),
    .item     (item),
    .valid    (dec_valid),
    .dec      (dec)
  );

  z80br_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .valid_in (dec_valid),
    .dec      (dec),
    .valid    (ex_valid),
    .ex       (ex)
  );

  z80br_select u_select (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .valid_in (ex_valid),
    .ex       (ex),
    .valid    (res_valid),
    .res      (res)
  );

  // drive the result channel
  assign result.valid        = res_valid;
  assign result.next_pc      = res.next_pc;
  assign result.next_b       = res.next_b;
  assign result.next_sp      = res.next_sp;
  assign result.push_valid   = res.push_valid;
  assign result.push_value   = res.push_value;
  assign result.pop_used     = res.pop_used;
  assign result.memptr_write = res.memptr_write;
  assign result.memptr_value = res.memptr_value;
  assign result.taken        = res.taken;

endmodule

// ===== sim/z80_branch_resolve_core_tb.sv =====
// ----------------------------------------------------------------------------
// z80_branch_resolve_core_tb
// Self-checking bench for the Z80 branch resolve core. A short table of
// directed requests covers wrap-around, every instruction kind and every
// condition code. A long random run follows. Each result is compared field
// by field against a hand-written result or the in-bench resolve model, with
// random idle cycles on the request side and random backpressure on the result side.
// ----------------------------------------------------------------------------
module z80_branch_resolve_core_tb import z80br_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS    = 1625;
  localparam int MAX_REPORTS    = 100;
  localparam int DRAIN_CYCLES   = 8;

  // one directed row: request plus an optional hand-written result
  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  z80br_in_if  instr_if ();
  z80br_out_if result_if ();

  z80_branch_resolve_core uut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_if),
    .result (result_if)
  );

  out_item_t pending_results[$];
  stim_row_t stim_rows[$];
  bit        steady;
  int        mismatches;
  int        sent_cnt;
  int        directed_cnt;
  int        checked_cnt;
  int        taken_cnt;
  int        push_cnt;
  int        pop_cnt;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // condition test on the flags
  function automatic logic cond_met(cond_t code, in_item_t req);
    case (code)
      CC_NZ:   return !req.flag_z;
      CC_Z:    return req.flag_z;
      CC_NC:   return !req.flag_c;
      CC_C:    return req.flag_c;
      CC_PO:   return !req.flag_pv;
      CC_PE:   return req.flag_pv;
      CC_P:    return !req.flag_s;
      default: return req.flag_s;
    endcase
  endfunction

  // next pc, b, sp, stack traffic and memptr for one instruction
  function automatic out_item_t resolve_branch(in_item_t req);
    out_item_t   r;
    logic [15:0] rel;
    logic        cc_long;
    logic        cc_short;
    r           = '0;
    r.next_pc   = req.pc;
    r.next_b    = req.reg_b;
    r.next_sp   = req.sp;
    rel         = req.pc + {{8{req.operand[7]}}, req.operand[7:0]};
    cc_long     = cond_met(cond_t'(req.opcode[5:3]), req);
    cc_short    = cond_met(cond_t'({1'b0, req.opcode[4:3]}), req);
    case (action_t'(req.action))
      ACT_DJNZ: begin
        r.next_b = req.reg_b - 8'd1;
        if (r.next_b != 8'd0) begin
          r.next_pc = rel;
          r.taken   = 1'b1;
        end
      end
      ACT_JR: begin
        r.next_pc      = rel;
        r.taken        = 1'b1;
        r.memptr_write = 1'b1;
        r.memptr_value = rel;
      end
      ACT_JR_CC: begin
        if (cc_short) begin
          r.next_pc = rel;
          r.taken   = 1'b1;
        end
      end
      ACT_JP: begin
        r.next_pc      = req.operand;
        r.taken        = 1'b1;
        r.memptr_write = 1'b1;
        r.memptr_value = req.operand;
      end
      ACT_JP_CC: begin
        r.memptr_write = 1'b1;
        r.memptr_value = req.operand;
        if (cc_long) begin
          r.next_pc = req.operand;
          r.taken   = 1'b1;
        end
      end
      ACT_JP_HL: begin
        r.next_pc = req.hl;
        r.taken   = 1'b1;
      end
      ACT_CALL, ACT_CALL_CC: begin
        r.memptr_write = 1'b1;
        r.memptr_value = req.operand;
        if (action_t'(req.action) == ACT_CALL || cc_long) begin
          r.next_sp    = req.sp - STACK_STEP;
          r.push_valid = 1'b1;
          r.push_value = req.pc;
          r.next_pc    = req.operand;
          r.taken      = 1'b1;
        end
      end
      ACT_RET: begin
        r.next_pc      = req.popped_value;
        r.next_sp      = req.sp + STACK_STEP;
        r.pop_used     = 1'b1;
        r.taken        = 1'b1;
        r.memptr_write = 1'b1;
        r.memptr_value = req.popped_value;
      end
      ACT_RET_CC: begin
        if (cc_long) begin
          r.next_pc  = req.popped_value;
          r.next_sp  = req.sp + STACK_STEP;
          r.pop_used = 1'b1;
          r.taken    = 1'b1;
        end
      end
      ACT_RST: begin
        r.next_sp      = req.sp - STACK_STEP;
        r.push_valid   = 1'b1;
        r.push_value   = req.pc + 16'd1;
        r.next_pc      = {8'h00, req.opcode & RST_MASK};
        r.taken        = 1'b1;
        r.memptr_write = 1'b1;
        r.memptr_value = r.next_pc;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t mk_req(logic [3:0] action, logic [7:0] opcode,
                                      logic [15:0] operand, logic [15:0] pc,
                                      logic [3:0] szpc, logic [7:0] reg_b,
                                      logic [15:0] hl, logic [15:0] sp,
                                      logic [15:0] popped);
    in_item_t q;
    q.action       = action;
    q.opcode       = opcode;
    q.operand      = operand;
    q.pc           = pc;
    q.flag_s       = szpc[3];
    q.flag_z       = szpc[2];
    q.flag_pv      = szpc[1];
    q.flag_c       = szpc[0];
    q.reg_b        = reg_b;
    q.hl           = hl;
    q.sp           = sp;
    q.popped_value = popped;
    return q;
  endfunction

  function automatic out_item_t mk_res(logic [15:0] next_pc, logic [7:0] next_b,
                                       logic [15:0] next_sp, logic push_valid,
                                       logic [15:0] push_value, logic pop_used,
                                       logic memptr_write, logic [15:0] memptr_value,
                                       logic taken);
    out_item_t r;
    r.next_pc      = next_pc;
    r.next_b       = next_b;
    r.next_sp      = next_sp;
    r.push_valid   = push_valid;
    r.push_value   = push_value;
    r.pop_used     = pop_used;
    r.memptr_write = memptr_write;
    r.memptr_value = memptr_value;
    r.taken        = taken;
    return r;
  endfunction

  function automatic void add_row(in_item_t req, bit typed, out_item_t res);
    stim_row_t row;
    row.req   = req;
    row.typed = typed;
    row.res   = res;
    stim_rows.push_back(row);
  endfunction

  // words at the edges of the 16-bit wrap
  function automatic logic [15:0] wrap_word(int idx);
    case (idx)
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFE;
      default: return 16'hFFFF;
    endcase
  endfunction

  // hold one request on the bus until it is taken
  task automatic send_request(in_item_t req, out_item_t want);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      instr_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_results.push_back(want);
    instr_if.valid        <= 1'b1;
    instr_if.action       <= req.action;
    instr_if.opcode       <= req.opcode;
    instr_if.operand      <= req.operand;
    instr_if.pc           <= req.pc;
    instr_if.flag_s       <= req.flag_s;
    instr_if.flag_z       <= req.flag_z;
    instr_if.flag_pv      <= req.flag_pv;
    instr_if.flag_c       <= req.flag_c;
    instr_if.reg_b        <= req.reg_b;
    instr_if.hl           <= req.hl;
    instr_if.sp           <= req.sp;
    instr_if.popped_value <= req.popped_value;
    do @(posedge clk); while (!instr_if.ready);
    sent_cnt++;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: result %0d %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, checked_cnt, name, want, got);
      mismatches++;
    end
  endtask

  // stimulus
  initial begin
    in_item_t  req;
    stim_row_t row;
    int        k;

    rst                    = 1'b1;
    steady                 = 1'b0;
    instr_if.valid         = 1'b0;
    instr_if.action        = '0;
    instr_if.opcode        = '0;
    instr_if.operand       = '0;
    instr_if.pc            = '0;
    instr_if.flag_s        = 1'b0;
    instr_if.flag_z        = 1'b0;
    instr_if.flag_pv       = 1'b0;
    instr_if.flag_c        = 1'b0;
    instr_if.reg_b         = '0;
    instr_if.hl            = '0;
    instr_if.sp            = '0;
    instr_if.popped_value  = '0;

    // directed rows: fields as action, opcode, operand, pc, szpc flags, b, hl, sp, popped
    add_row(mk_req(ACT_NOP, 8'h00, 16'h0000, 16'h0000, 4'b0000, 8'h00, 16'h0000,
                   16'h0000, 16'h0000), 1'b1,
            mk_res(16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0));
    add_row(mk_req(ACT_NOP, 8'hFF, 16'hFFFF, 16'hFFFF, 4'b1111, 8'hFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF), 1'b1,
            mk_res(16'hFFFF, 8'hFF, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0));
    // undefined action code behaves as nop
    add_row(mk_req(4'hF, 8'hFF, 16'hFFFF, 16'hFFFF, 4'b1111, 8'hFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF), 1'b1,
            mk_res(16'hFFFF, 8'hFF, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0));
    // djnz reaching zero, then b wrapping from zero with a backward offset
    add_row(mk_req(ACT_DJNZ, 8'h10, 16'h00FE, 16'h1234, 4'b0000, 8'h01, 16'h0000,
                   16'h8000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_DJNZ, 8'h10, 16'hAB80, 16'h0010, 4'b1111, 8'h00, 16'h0000,
                   16'h8000, 16'h0000), 1'b0, '0);
    // jr extremes of the signed offset, wrapping pc both ways
    add_row(mk_req(ACT_JR, 8'h18, 16'h007F, 16'hFFF0, 4'b0000, 8'h33, 16'h0000,
                   16'h4000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_JR, 8'h18, 16'hFF80, 16'h0000, 4'b1111, 8'h33, 16'h0000,
                   16'h4000, 16'h0000), 1'b0, '0);
    // jr cc: only the low two condition bits count
    add_row(mk_req(ACT_JR_CC, 8'h20, 16'h0005, 16'h2000, 4'b1011, 8'h00, 16'h0000,
                   16'h0000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_JR_CC, 8'h28, 16'h0005, 16'h2000, 4'b1011, 8'h00, 16'h0000,
                   16'h0000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_JR_CC, 8'h30, 16'h00F0, 16'h2000, 4'b0001, 8'h00, 16'h0000,
                   16'h0000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_JR_CC, 8'h38, 16'h00F0, 16'h2000, 4'b0001, 8'h00, 16'h0000,
                   16'h0000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_JP, 8'hC3, 16'hFFFF, 16'h0100, 4'b0000, 8'h00, 16'h0000,
                   16'h0000, 16'h0000), 1'b0, '0);
    // jp cc on parity and sign, memptr written even when not taken
    add_row(mk_req(ACT_JP_CC, 8'hE2, 16'h4321, 16'h0100, 4'b0000, 8'h00, 16'h0000,
                   16'h0000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_JP_CC, 8'hEA, 16'h4321, 16'h0100, 4'b0000, 8'h00, 16'h0000,
                   16'h0000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_JP_CC, 8'hF2, 16'h8765, 16'h0100, 4'b0110, 8'h00, 16'h0000,
                   16'h0000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_JP_CC, 8'hFA, 16'h8765, 16'h0100, 4'b0110, 8'h00, 16'h0000,
                   16'h0000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_JP_HL, 8'hE9, 16'h1111, 16'h0100, 4'b0000, 8'h00, 16'hFFFF,
                   16'h0000, 16'h0000), 1'b0, '0);
    // call with sp wrapping below zero
    add_row(mk_req(ACT_CALL, 8'hCD, 16'h5000, 16'hFFFF, 4'b0000, 8'h00, 16'h0000,
                   16'h0000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_CALL_CC, 8'hC4, 16'h6000, 16'h0200, 4'b0100, 8'h00, 16'h0000,
                   16'h9000, 16'h0000), 1'b0, '0);
    add_row(mk_req(ACT_CALL_CC, 8'hDC, 16'h6000, 16'h0200, 4'b0001, 8'h00, 16'h0000,
                   16'h0001, 16'h0000), 1'b0, '0);
    // ret with sp wrapping above ffff
    add_row(mk_req(ACT_RET, 8'hC9, 16'h0000, 16'h0300, 4'b0000, 8'h00, 16'h0000,
                   16'hFFFE, 16'hFFFF), 1'b0, '0);
    add_row(mk_req(ACT_RET_CC, 8'hC8, 16'h0000, 16'h0300, 4'b1011, 8'h00, 16'h0000,
                   16'hFFFF, 16'h7777), 1'b0, '0);
    add_row(mk_req(ACT_RET_CC, 8'hF8, 16'h0000, 16'h0300, 4'b1000, 8'h00, 16'h0000,
                   16'hFFFF, 16'h7777), 1'b0, '0);
    // rst with every opcode bit set: vector 38, pc+1 and sp-2 both wrap
    add_row(mk_req(ACT_RST, 8'hFF, 16'h0000, 16'hFFFF, 4'b0000, 8'h55, 16'h0000,
                   16'h0000, 16'h0000), 1'b1,
            mk_res(16'h0038, 8'h55, 16'hFFFE, 1'b1, 16'h0000, 1'b0, 1'b1, 16'h0038, 1'b1));
    add_row(mk_req(ACT_RST, 8'hC7, 16'hFFFF, 16'h1000, 4'b1111, 8'h00, 16'hFFFF,
                   16'h2000, 16'hFFFF), 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      send_request(row.req, row.typed ? row.res : resolve_branch(row.req));
    end
    directed_cnt = sent_cnt;

    // random part, with stretches of back-to-back traffic
    for (k = 0; k < RANDOM_REQS; k++) begin
      steady = ((k / 150) % 4) == 3;
      if ($urandom_range(0, 9) == 0)
        req.action = 4'($urandom_range(12, 15));
      else
        req.action = 4'($urandom_range(0, 11));
      req.opcode       = 8'($urandom);
      req.operand      = 16'($urandom);
      req.pc           = ($urandom_range(0, 7) == 0) ? wrap_word($urandom_range(0, 3))
                                                     : 16'($urandom);
      req.flag_s       = 1'($urandom_range(0, 1));
      req.flag_z       = 1'($urandom_range(0, 1));
      req.flag_pv      = 1'($urandom_range(0, 1));
      req.flag_c       = 1'($urandom_range(0, 1));
      req.reg_b        = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 2))
                                                     : 8'($urandom);
      req.hl           = 16'($urandom);
      req.sp           = ($urandom_range(0, 7) == 0) ? wrap_word($urandom_range(0, 3))
                                                     : 16'($urandom);
      req.popped_value = 16'($urandom);
      send_request(req, resolve_branch(req));
    end
    instr_if.valid <= 1'b0;
    steady = 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests (%0d directed, %0d random), checked %0d results",
             sent_cnt, directed_cnt, sent_cnt - directed_cnt, checked_cnt);
    $display("branches taken %0d, stack pushes %0d, stack pops %0d, field mismatches %0d",
             taken_cnt, push_cnt, pop_cnt, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: random backpressure and field-by-field check
  initial begin
    out_item_t want;
    int        stall;
    result_if.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      if (pending_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result with no request outstanding, next_pc 0x%0h",
                   $time, result_if.next_pc);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc",      want.next_pc,      result_if.next_pc);
        check_field("next_b",       16'(want.next_b),  16'(result_if.next_b));
        check_field("next_sp",      want.next_sp,      result_if.next_sp);
        check_field("push_valid",   16'(want.push_valid), 16'(result_if.push_valid));
        check_field("push_value",   want.push_value,   result_if.push_value);
        check_field("pop_used",     16'(want.pop_used), 16'(result_if.pop_used));
        check_field("memptr_write", 16'(want.memptr_write), 16'(result_if.memptr_write));
        check_field("memptr_value", want.memptr_value, result_if.memptr_value);
        check_field("taken",        16'(want.taken),   16'(result_if.taken));
        taken_cnt += int'(want.taken);
        push_cnt  += int'(want.push_valid);
        pop_cnt   += int'(want.pop_used);
        checked_cnt++;
      end
    end
  end

  // watchdog
  initial begin
    #500us;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
